// ===== rtl/wrg_pkg.sv =====
// Shared types and constants of the windowed RMS gain envelope core.
// No dependencies; wrg_gain_unit and the top-level core import this package.
package wrg_pkg;

    // Configuration port layout and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOG2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK      = 3'd4;

    // Fixed field widths.
    localparam int LEVEL_W = 15;
    localparam int INDEX_W = 32;
    localparam int LOG2_W  = 4;

    // Window size lower limit and register reset values.
    localparam logic [LOG2_W-1:0]  WLOG2_MIN   = 4'd4;
    localparam logic [LOG2_W-1:0]  WLOG2_RESET = 4'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd3277;

    // Request kinds carried in tuser.
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Sequencer of the main datapath.
    typedef enum logic [7:0] {
        C_IDLE   = 8'b0000_0001,
        C_GSTART = 8'b0000_0010,
        C_GWAIT  = 8'b0000_0100,
        C_RAMP   = 8'b0000_1000,
        C_SUM    = 8'b0001_0000,
        C_MUL    = 8'b0010_0000,
        C_SAT    = 8'b0100_0000,
        C_OUT    = 8'b1000_0000
    } t_ctl_state;

    // Sequencer of the gain unit.
    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_DIV  = 5'b00010,
        M_SQRT = 5'b00100,
        M_GDIV = 5'b01000,
        M_DONE = 5'b10000
    } t_gu_state;

endpackage

// ===== rtl/wrg_ram.sv =====
// Generic simple dual-port RAM with one registered read port.
// No dependencies. A read at the address being written returns the old data.
module wrg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read-old-data read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wrg_gain_unit.sv =====
// Window gain unit: mean by restoring division, integer square root, then
// target/RMS by a second division, one bit a cycle. Depends on wrg_pkg.
module wrg_gain_unit
    import wrg_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = 12,
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_FRAC_BITS  = 12
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [2*SAMPLE_BITS+MAX_WINDOW_LOG2-2:0]    i_sum,
    input  logic [MAX_WINDOW_LOG2:0]                    i_count,
    input  logic [INDEX_W-1:0]                          i_base,
    input  logic [LEVEL_W-1:0]                          i_min_level,
    input  logic [LEVEL_W-1:0]                          i_target_level,
    input  logic [INDEX_W-1:0]                          i_tail_start,
    input  logic [INDEX_W-1:0]                          i_attack,
    output logic                                        o_done,
    output logic [GAIN_FRAC_BITS+3:0]                   o_gain
);

    localparam int SUM_W  = 2 * SAMPLE_BITS + MAX_WINDOW_LOG2 - 1;
    localparam int CNT_W  = MAX_WINDOW_LOG2 + 1;
    localparam int G_W    = GAIN_FRAC_BITS + 4;
    localparam int NUM2_W = LEVEL_W + GAIN_FRAC_BITS;
    localparam int DIV_W  = (SUM_W > NUM2_W) ? SUM_W : NUM2_W;
    localparam int RT_W   = (SUM_W + 1) / 2;
    localparam int SQ_W   = 2 * RT_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam logic [G_W-1:0]   GAIN_UNITY = G_W'(1) << GAIN_FRAC_BITS;
    localparam logic [G_W-1:0]   GAIN_MAX   = G_W'(10) << GAIN_FRAC_BITS;
    localparam logic [G_W-1:0]   GAIN_MIN   = G_W'(((1 << GAIN_FRAC_BITS) + 5) / 10);

    t_gu_state           r_state;
    logic [STEP_W-1:0]   r_step;
    logic [DIV_W-1:0]    r_num;
    logic [DIV_W-1:0]    r_den;
    logic [DIV_W:0]      r_rem;
    logic [SQ_W-1:0]     r_sv;
    logic [RT_W+1:0]     r_srem;
    logic [RT_W-1:0]     r_root;
    logic [G_W-1:0]      r_gain;

    logic [DIV_W:0]      div_t;
    logic                div_ge;
    logic [RT_W+1:0]     sq_t;
    logic [RT_W+1:0]     sq_trial;
    logic                sq_ge;

    // One restoring division step.
    always_comb begin
        div_t  = {r_rem[DIV_W-1:0], r_num[DIV_W-1]};
        div_ge = (div_t >= {1'b0, r_den});
    end

    // One square root step, two radicand bits at a time.
    always_comb begin
        sq_t     = {r_srem[RT_W-1:0], r_sv[SQ_W-1:SQ_W-2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_t >= sq_trial);
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        r_srem <= '0;
                        r_root <= '0;
                        if (i_base >= i_tail_start || i_base < i_attack) begin
                            r_gain  <= GAIN_UNITY;
                            r_state <= M_DONE;
                        end else if (i_count == '0) begin
                            r_sv    <= '0;
                            r_state <= M_SQRT;
                        end else begin
                            r_num   <= DIV_W'(i_sum);
                            r_den   <= DIV_W'(i_count);
                            r_state <= M_DIV;
                        end
                    end
                end
                M_DIV, M_GDIV: begin
                    if (r_step == STEP_W'(DIV_W)) begin
                        r_step <= '0;
                        if (r_state == M_DIV) begin
                            r_sv    <= SQ_W'(r_num[SUM_W-1:0]);
                            r_state <= M_SQRT;
                        end else begin
                            if (r_num > DIV_W'(GAIN_MAX)) begin
                                r_gain <= GAIN_MAX;
                            end else if (r_num < DIV_W'(GAIN_MIN)) begin
                                r_gain <= GAIN_MIN;
                            end else begin
                                r_gain <= r_num[G_W-1:0];
                            end
                            r_state <= M_DONE;
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                        r_rem  <= div_ge ? (div_t - {1'b0, r_den}) : div_t;
                        r_num  <= {r_num[DIV_W-2:0], div_ge};
                    end
                end
                M_SQRT: begin
                    if (r_step == STEP_W'(RT_W)) begin
                        r_step <= '0;
                        if (DIV_W'(r_root) < DIV_W'(i_min_level)) begin
                            r_gain  <= GAIN_UNITY;
                            r_state <= M_DONE;
                        end else if (r_root == '0) begin
                            r_gain  <= GAIN_MAX;
                            r_state <= M_DONE;
                        end else begin
                            r_num   <= DIV_W'({i_target_level, {GAIN_FRAC_BITS{1'b0}}});
                            r_den   <= DIV_W'(r_root);
                            r_rem   <= '0;
                            r_state <= M_GDIV;
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                        r_srem <= sq_ge ? (sq_t - sq_trial) : sq_t;
                        r_root <= {r_root[RT_W-2:0], sq_ge};
                        r_sv   <= {r_sv[SQ_W-3:0], 2'b00};
                    end
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == M_DONE);
    assign o_gain = r_gain;

endmodule

// ===== rtl/windowed_rms_gain_envelope_core.sv =====
// Windowed RMS gain envelope core: top level with the item sequencer, the
// sample delay store and the gain ramp datapath. Depends on wrg_pkg,
// wrg_ram and wrg_gain_unit.
//
// Samples are held two windows in an on-chip store and leave scaled by a gain
// that ramps from their window's gain toward the next one. Items are handled
// one at a time. A push that emits no sample and closes no window returns the
// sequencer straight to idle; one that emits passes the ramp, sum, multiply,
// saturate and output states and waits on output backpressure; a drain tick
// that emits does the same, after a gain start state at the first sample of a
// window, and a drain tick with nothing held leaves the sequencer idle. Each gain
// computation holds the sequencer in the gain unit after a start state: 43-bit
// mean and gain divisions and a 22-bit square root at default sizes, one bit a cycle.
// The store needs no clearing pass: every entry is written before it is read.
// Configuration writes are taken at any time on the plain write port;
// window_log2 takes effect only while no stream is in progress.
module windowed_rms_gain_envelope_core
    import wrg_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = 12,
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_FRAC_BITS  = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream. tdata: sample_value; tuser: req_type.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  i_s_tdata,
    input  logic                              i_s_tuser,
    // Output stream. tdata: out_sample; tlast: is_last.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  o_m_tdata,
    output logic                              o_m_tlast,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_W = 2 * SAMPLE_BITS + MAX_WINDOW_LOG2 - 1;
    localparam int CNT_W = MAX_WINDOW_LOG2 + 1;
    localparam int AW    = MAX_WINDOW_LOG2 + 1;
    localparam int G_W   = GAIN_FRAC_BITS + 4;
    localparam int PR_W  = CNT_W + G_W;
    localparam int P_W   = SB + G_W + 1;
    localparam logic [G_W-1:0] GAIN_UNITY = G_W'(1) << GAIN_FRAC_BITS;
    localparam logic signed [P_W-1:0] OUT_MAX = P_W'((1 << (SB - 1)) - 1);
    localparam logic signed [P_W-1:0] OUT_MIN = ~OUT_MAX;

    // Configuration registers.
    logic [LOG2_W-1:0]  r_log2;
    logic [LEVEL_W-1:0] r_min_level;
    logic [LEVEL_W-1:0] r_target;
    logic [INDEX_W-1:0] r_tail_start;
    logic [INDEX_W-1:0] r_attack;

    // Stream state.
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_fill;
    logic [INDEX_W-1:0] r_stream;
    logic [INDEX_W-1:0] r_emit;
    logic [G_W-1:0]     r_gain_old;
    logic [G_W-1:0]     r_gain_new;
    logic               r_draining;

    // Item sequencing.
    t_ctl_state         r_state;
    t_ctl_state         n_state;
    logic               r_shift;
    logic               r_calc;
    logic               r_copy;
    logic               r_emit_after;
    logic               r_gain_after;
    logic [SUM_W-1:0]   r_msum;
    logic [CNT_W-1:0]   r_mcnt;
    logic [INDEX_W-1:0] r_mbase;
    logic [CNT_W-1:0]   r_j;
    logic               r_last;

    // Emission datapath.
    logic [PR_W-1:0]        r_pa;
    logic [PR_W-1:0]        r_pb;
    logic [G_W-1:0]         r_rgain;
    logic signed [P_W-1:0]  r_prod;
    logic [SB-1:0]          r_odata;

    logic               accept;
    logic               is_push;
    logic               idle;
    logic [CNT_W-1:0]   wsize;
    logic [INDEX_W-1:0] wmask;
    logic               clr;
    logic [INDEX_W-1:0] e_stream;
    logic [INDEX_W-1:0] e_emit;
    logic [SUM_W-1:0]   e_sum;
    logic [CNT_W-1:0]   e_fill;
    logic               push_emit;
    logic signed [SB-1:0]     s_in;
    logic signed [2*SB-1:0]   sq;
    logic [SUM_W-1:0]   new_sum;
    logic [CNT_W-1:0]   new_fill;
    logic               close;
    logic [INDEX_W-1:0] base;
    logic [INDEX_W-1:0] gap;
    logic               at_edge;
    logic               d_shift;
    logic               d_calc;
    logic               d_copy;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [SB-1:0]      ram_rdata;
    logic               gu_start;
    logic               gu_done;
    logic [G_W-1:0]     gu_gain;
    logic [CNT_W:0]     ramp_sum;
    logic signed [P_W-1:0] shifted;
    logic [LOG2_W-1:0]  cfg_log2;

    assign accept  = i_s_tvalid && o_s_tready;
    assign is_push = (i_s_tuser == REQ_PUSH);
    assign idle    = (r_stream == '0) || (r_draining && r_emit == r_stream);
    assign wsize   = CNT_W'(1) << r_log2;
    assign wmask   = INDEX_W'(wsize) - INDEX_W'(1);
    assign s_in    = signed'(i_s_tdata[SB-1:0]);

    // Push path: a stream that has finished draining restarts from empty.
    always_comb begin
        clr       = r_draining && (r_emit == r_stream);
        e_stream  = clr ? '0 : r_stream;
        e_emit    = clr ? '0 : r_emit;
        e_sum     = clr ? '0 : r_sum;
        e_fill    = clr ? '0 : r_fill;
        push_emit = (e_stream - e_emit) == (INDEX_W'(wsize) << 1);
        sq        = s_in * s_in;
        new_sum   = e_sum + SUM_W'(unsigned'(sq));
        new_fill  = e_fill + CNT_W'(1);
        close     = (new_fill >= wsize);
    end

    // Drain path: gain bookkeeping at the first sample of each window.
    always_comb begin
        base    = r_stream - INDEX_W'(r_fill);
        gap     = base - r_emit;
        at_edge = ((r_emit & wmask) == '0);
        d_shift = 1'b0;
        d_calc  = 1'b0;
        d_copy  = 1'b0;
        if (at_edge && gap == INDEX_W'(wsize)) begin
            d_shift = 1'b1;
            d_calc  = (r_fill != '0);
        end else if (at_edge && gap == '0) begin
            if (base == '0) begin
                d_calc = 1'b1;
                d_copy = 1'b1;
            end else begin
                d_shift = 1'b1;
            end
        end
    end

    // Store access: the write of a push and the read of the emitted sample.
    assign ram_we    = accept && is_push && !(r_draining && !clr);
    assign ram_re    = accept && (is_push ? (!(r_draining && !clr) && push_emit)
                                          : (r_emit != r_stream));
    assign ram_raddr = is_push ? e_emit[AW-1:0] : r_emit[AW-1:0];

    wrg_ram #(
        .WIDTH (SB),
        .DEPTH (1 << AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (e_stream[AW-1:0]),
        .i_wdata (i_s_tdata[SB-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign gu_start = (r_state == C_GSTART) && r_calc;

    wrg_gain_unit #(
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_gain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (gu_start),
        .i_sum          (r_msum),
        .i_count        (r_mcnt),
        .i_base         (r_mbase),
        .i_min_level    (r_min_level),
        .i_target_level (r_target),
        .i_tail_start   (r_tail_start),
        .i_attack       (r_attack),
        .o_done         (gu_done),
        .o_gain         (gu_gain)
    );

    // Next sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        if (!(r_draining && !clr)) begin
                            if (push_emit) begin
                                n_state = C_RAMP;
                            end else if (close) begin
                                n_state = C_GSTART;
                            end
                        end
                    end else if (r_emit != r_stream) begin
                        n_state = (d_shift || d_calc) ? C_GSTART : C_RAMP;
                    end
                end
            end
            C_GSTART: begin
                if (r_calc) begin
                    n_state = C_GWAIT;
                end else begin
                    n_state = r_emit_after ? C_RAMP : C_IDLE;
                end
            end
            C_GWAIT: begin
                if (gu_done) begin
                    n_state = r_emit_after ? C_RAMP : C_IDLE;
                end
            end
            C_RAMP: n_state = C_SUM;
            C_SUM:  n_state = C_MUL;
            C_MUL:  n_state = C_SAT;
            C_SAT:  n_state = C_OUT;
            C_OUT: begin
                if (i_m_tready) begin
                    n_state = r_gain_after ? C_GSTART : C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // Clamp of a window size write.
    always_comb begin
        cfg_log2 = i_cfg_data[LOG2_W-1:0];
        if (cfg_log2 < WLOG2_MIN) begin
            cfg_log2 = WLOG2_MIN;
        end else if (cfg_log2 > LOG2_W'(MAX_WINDOW_LOG2)) begin
            cfg_log2 = LOG2_W'(MAX_WINDOW_LOG2);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2       <= WLOG2_RESET;
            r_min_level  <= LEVEL_RESET;
            r_target     <= LEVEL_RESET;
            r_tail_start <= '1;
            r_attack     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LOG2: if (idle) r_log2 <= cfg_log2;
                CFG_MIN_LEVEL:   r_min_level  <= i_cfg_data[LEVEL_W-1:0];
                CFG_TARGET:      r_target     <= i_cfg_data[LEVEL_W-1:0];
                CFG_TAIL_START:  r_tail_start <= i_cfg_data[INDEX_W-1:0];
                CFG_ATTACK:      r_attack     <= i_cfg_data[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    // Stream state and item bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= C_IDLE;
            r_sum        <= '0;
            r_fill       <= '0;
            r_stream     <= '0;
            r_emit       <= '0;
            r_gain_old   <= GAIN_UNITY;
            r_gain_new   <= GAIN_UNITY;
            r_draining   <= 1'b0;
            r_shift      <= 1'b0;
            r_calc       <= 1'b0;
            r_copy       <= 1'b0;
            r_emit_after <= 1'b0;
            r_gain_after <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == C_IDLE && accept) begin
                if (is_push) begin
                    if (!(r_draining && !clr)) begin
                        if (clr) begin
                            r_gain_old <= GAIN_UNITY;
                            r_gain_new <= GAIN_UNITY;
                            r_draining <= 1'b0;
                        end
                        r_stream     <= e_stream + INDEX_W'(1);
                        r_emit       <= push_emit ? e_emit + INDEX_W'(1) : e_emit;
                        r_j          <= e_emit[CNT_W-1:0] & wmask[CNT_W-1:0];
                        r_last       <= 1'b0;
                        r_shift      <= close;
                        r_calc       <= close;
                        r_copy       <= 1'b0;
                        r_emit_after <= 1'b0;
                        r_gain_after <= close && push_emit;
                        r_msum       <= new_sum;
                        r_mcnt       <= wsize;
                        r_mbase      <= e_stream - INDEX_W'(wsize - CNT_W'(1));
                        if (close) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                        end else begin
                            r_sum  <= new_sum;
                            r_fill <= new_fill;
                        end
                    end
                end else begin
                    r_draining <= 1'b1;
                    if (r_emit != r_stream) begin
                        r_emit       <= r_emit + INDEX_W'(1);
                        r_j          <= r_emit[CNT_W-1:0] & wmask[CNT_W-1:0];
                        r_last       <= (r_emit + INDEX_W'(1) == r_stream);
                        r_shift      <= d_shift;
                        r_calc       <= d_calc;
                        r_copy       <= d_copy;
                        r_emit_after <= 1'b1;
                        r_gain_after <= 1'b0;
                        r_msum       <= r_sum;
                        r_mcnt       <= r_fill;
                        r_mbase      <= base;
                    end
                end
            end
            // Gain hand-over between windows.
            if (r_state == C_GSTART) begin
                r_gain_after <= 1'b0;
                if (r_shift) begin
                    r_gain_old <= r_gain_new;
                end
            end
            if (r_state == C_GWAIT && gu_done) begin
                r_gain_new <= gu_gain;
                if (r_copy) begin
                    r_gain_old <= gu_gain;
                end
            end
        end
    end

    // Ramp gain: weighted blend of the two window gains.
    assign ramp_sum = {1'b0, CNT_W'(0)};
    always_ff @(posedge i_clk) begin
        if (r_state == C_RAMP) begin
            r_pa <= PR_W'(wsize - r_j) * PR_W'(r_gain_old);
            r_pb <= PR_W'(r_j) * PR_W'(r_gain_new);
        end
        if (r_state == C_SUM) begin
            r_rgain <= G_W'(({1'b0, r_pa} + {1'b0, r_pb}
                             + (PR_W + 1)'(ramp_sum)) >> r_log2);
        end
        if (r_state == C_MUL) begin
            r_prod <= P_W'(signed'(ram_rdata)) * signed'({1'b0, r_rgain});
        end
        if (r_state == C_SAT) begin
            if (shifted > OUT_MAX) begin
                r_odata <= OUT_MAX[SB-1:0];
            end else if (shifted < OUT_MIN) begin
                r_odata <= OUT_MIN[SB-1:0];
            end else begin
                r_odata <= shifted[SB-1:0];
            end
        end
    end

    // Floor of the product in Q1.15.
    assign shifted = r_prod >>> GAIN_FRAC_BITS;

    assign o_s_tready = (r_state == C_IDLE);
    assign o_m_tvalid = (r_state == C_OUT);
    assign o_m_tdata  = TD_W'(r_odata);
    assign o_m_tlast  = r_last;

endmodule
